/* rtl/core/lpwt_pkg.sv */
// Listener port watch table: shared types, constants and the default port table.
// No dependencies; used by every module of the block.
`default_nettype none
package lpwt_pkg;

  localparam int TABLE_DEPTH  = 128;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int NUM_DEFAULTS = 5;
  localparam int DFLT_W       = $clog2(NUM_DEFAULTS);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REPLY  = 2'd2;

  localparam logic [1:0] MATCH_NONE = 2'd0;
  localparam logic [1:0] MATCH_DST  = 2'd1;
  localparam logic [1:0] MATCH_SRC  = 2'd2;

  localparam logic [15:0] LISTENER_PORT  = 16'd6002;
  localparam logic [7:0]  MSG_TYPE_REPLY = 8'h02;
  localparam logic [7:0]  MSG_BYTE14_REQ = 8'h00;
  localparam logic [7:0]  MSG_BYTE15_REQ = 8'h11;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_LOOKUP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] port;
    logic [15:0] dst;
    logic [14:0] learned;
  } cmd_t;

  typedef struct packed {
    logic [14:0] learned_port;
    logic        table_full;
    logic        port_added;
    logic [1:0]  match_code;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
  } stat_t;

  function automatic logic [15:0] default_port(input logic [DFLT_W-1:0] idx);
    logic [15:0] port;
    case (idx)
      3'd0: port = 16'd6002;
      3'd1: port = 16'd3857;
      3'd2: port = 16'd3949;
      3'd3: port = 16'd4119;
      3'd4: port = 16'd4246;
      default: port = 16'd0;
    endcase
    return port;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/lpwt_front.sv */
// Front end: accepts input items and turns them into table commands.
// Depends on lpwt_pkg.
`default_nettype none
module lpwt_front (
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           in_kind_i,
  input  wire logic [71:0]          in_data_i,
  input  wire logic                 q_full_i,
  output logic                      in_ready_o,
  output logic                      q_push_o,
  output lpwt_pkg::cmd_t            q_cmd_o
);

  logic [15:0] port_value;
  logic [15:0] dest_port;
  logic [7:0]  b0, b14, b15, b16, b17;
  logic        reply_ok;
  logic [6:0]  hi_part;

  assign port_value = in_data_i[15:0];
  assign dest_port  = in_data_i[31:16];
  assign b0         = in_data_i[39:32];
  assign b14        = in_data_i[47:40];
  assign b15        = in_data_i[55:48];
  assign b16        = in_data_i[63:56];
  assign b17        = in_data_i[71:64];

  assign reply_ok = (port_value == lpwt_pkg::LISTENER_PORT) &&
                    (b0 == lpwt_pkg::MSG_TYPE_REPLY) &&
                    (b14 == lpwt_pkg::MSG_BYTE14_REQ) &&
                    (b15 == lpwt_pkg::MSG_BYTE15_REQ);
  assign hi_part  = b17[7:1] | {6'd0, b17[0]};

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.op      = lpwt_pkg::OP_NONE;
    q_cmd_o.port    = port_value;
    q_cmd_o.dst     = dest_port;
    q_cmd_o.learned = 15'd0;
    case (in_kind_i)
      lpwt_pkg::KIND_ADD: begin
        if (port_value != 16'd0) begin
          q_cmd_o.op = lpwt_pkg::OP_ADD;
        end
      end
      lpwt_pkg::KIND_LOOKUP: begin
        q_cmd_o.op = lpwt_pkg::OP_LOOKUP;
      end
      lpwt_pkg::KIND_REPLY: begin
        if (reply_ok) begin
          q_cmd_o.op      = lpwt_pkg::OP_ADD;
          q_cmd_o.learned = {hi_part, 1'b0, b16[6:0]};
          q_cmd_o.port    = {1'b0, hi_part, 1'b0, b16[6:0]};
        end
      end
      default: q_cmd_o.op = lpwt_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/lpwt_queue.sv */
// Short command queue between front end and table engine.
// Depends on lpwt_pkg.
`default_nettype none
module lpwt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lpwt_pkg::cmd_t push_cmd_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                valid_o,
  output lpwt_pkg::cmd_t      head_o
);

  lpwt_pkg::cmd_t                  slot_q [lpwt_pkg::QUEUE_DEPTH];
  logic [lpwt_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lpwt_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lpwt_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == lpwt_pkg::QCNT_W'(lpwt_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lpwt_back.sv */
// Table engine: port table memory, entry count, ordered scan and result register.
// Depends on lpwt_pkg.
`default_nettype none
module lpwt_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire lpwt_pkg::cmd_t  q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lpwt_pkg::result_t    out_res_o,
  output lpwt_pkg::stat_t      stat_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int IW = lpwt_pkg::IDX_W;
  localparam int CW = lpwt_pkg::CNT_W;

  logic [15:0]        mem [lpwt_pkg::TABLE_DEPTH];
  logic [15:0]        rd_data_q;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;

  logic [1:0]         state_q, state_d;
  lpwt_pkg::cmd_t     cmd_q, cmd_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      issue_q, issue_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]      cmp_idx_q, cmp_idx_d;
  lpwt_pkg::result_t  res_q, res_d;
  logic               out_vld_q, out_vld_d;
  lpwt_pkg::result_t  out_q, out_d;

  logic [15:0]        cmp_data;
  logic               hit_dst, hit_src;
  logic               out_free;

  assign rd_addr  = issue_q[IW-1:0];
  assign wr_addr  = cnt_q[IW-1:0];
  assign cmp_data = (cmp_idx_q < IW'(lpwt_pkg::NUM_DEFAULTS)) ?
                    lpwt_pkg::default_port(cmp_idx_q[lpwt_pkg::DFLT_W-1:0]) : rd_data_q;
  assign hit_dst  = cmp_vld_q && (cmp_data == cmd_q.dst);
  assign hit_src  = cmp_vld_q && (cmp_data == cmd_q.port);
  assign out_free = !out_vld_q || out_ready_i;

  assign out_valid_o        = out_vld_q;
  assign out_res_o          = out_q;
  assign stat_o.entry_count = cnt_q;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    issue_d   = issue_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    q_pop_o   = 1'b0;
    wr_en     = 1'b0;

    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          issue_d = '0;
          state_d = (q_head_i.op == lpwt_pkg::OP_LOOKUP) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d              = '0;
        res_d.learned_port = cmd_q.learned;
        if (cmd_q.op == lpwt_pkg::OP_ADD) begin
          if (cnt_q < CW'(lpwt_pkg::TABLE_DEPTH)) begin
            wr_en            = 1'b1;
            cnt_d            = cnt_q + 1'b1;
            res_d.port_added = 1'b1;
          end else begin
            res_d.table_full = 1'b1;
          end
        end
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        res_d = '0;
        if (hit_dst) begin
          res_d.match_code = lpwt_pkg::MATCH_DST;
          state_d          = ST_DONE;
        end else if (hit_src) begin
          res_d.match_code = lpwt_pkg::MATCH_SRC;
          state_d          = ST_DONE;
        end else if (issue_q == cnt_q) begin
          res_d.match_code = lpwt_pkg::MATCH_NONE;
          state_d          = ST_DONE;
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IW-1:0];
          issue_d   = issue_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= CW'(lpwt_pkg::NUM_DEFAULTS);
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_q.port;
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/core/listener_port_watch_table_unit.sv */
// Listener port watch table, top level: front end, command queue and table engine.
// A lookup scans the table entries in order, one table entry per cycle through the
// single memory read port. The front end takes new items while the engine works,
// up to two queued commands.
// Reset (rst_ni low, asynchronous) sets the count to five default ports, held as
// constants; no clearing pass, items are accepted from the first cycle after reset.
`default_nettype none
module listener_port_watch_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // port_value[15:0], dest_port[31:16], msg_type_byte[39:32], msg_byte14[47:40],
  // msg_byte15[55:48], msg_byte16[63:56], msg_byte17[71:64]
  input  wire logic [71:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // match_code[1:0], port_added[2], table_full[3], learned_port[18:4], zero[23:19]
  output logic [23:0]      m_axis_tdata
);

  logic               q_push, q_pop, q_full, q_valid;
  lpwt_pkg::cmd_t     push_cmd, head_cmd;
  lpwt_pkg::result_t  res;
  lpwt_pkg::stat_t    stat;

  lpwt_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  lpwt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  lpwt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .stat_o      (stat)
  );

  assign m_axis_tdata = {5'd0, res.learned_port, res.table_full, res.port_added,
                         res.match_code};

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.entry_count >= lpwt_pkg::CNT_W'(lpwt_pkg::NUM_DEFAULTS)) &&
    (stat.entry_count <= lpwt_pkg::CNT_W'(lpwt_pkg::TABLE_DEPTH)))
    else $error("entry count out of range");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.table_full) |->
    (stat.entry_count == lpwt_pkg::CNT_W'(lpwt_pkg::TABLE_DEPTH)))
    else $error("table full reported with room left");

  a_add_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.port_added || res.table_full)) |->
    (res.match_code == lpwt_pkg::MATCH_NONE) && !(res.port_added && res.table_full))
    else $error("inconsistent result flags");
`endif

endmodule
`default_nettype wire

/* tb/listener_port_watch_table_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for listener_port_watch_table_unit: streams add, lookup and listener reply
// items in random bursts against a stalling receiver and checks each result against a
// scoreboard holding its own copy of the port table. Depends on lpwt_pkg.
module listener_port_watch_table_unit_tb;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int ITEM_GOAL    = 1750;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 200;

  // matches the s_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [7:0]  b17;
    logic [7:0]  b16;
    logic [7:0]  b15;
    logic [7:0]  b14;
    logic [7:0]  msg_type;
    logic [15:0] dst;
    logic [15:0] port;
  } watch_item_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PULSED} rx_mode_e;

  class watch_table_scoreboard;
    logic [15:0]       ports [lpwt_pkg::TABLE_DEPTH];
    int unsigned       used;
    lpwt_pkg::result_t expected_results [$];
    int unsigned       mismatch_count;

    function new();
      ports[0] = 16'd6002;
      ports[1] = 16'd3857;
      ports[2] = 16'd3949;
      ports[3] = 16'd4119;
      ports[4] = 16'd4246;
      used = 5;
      mismatch_count = 0;
    endfunction

    function bit append_port(input logic [15:0] port);
      if (used < lpwt_pkg::TABLE_DEPTH) begin
        ports[used] = port;
        used++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [1:0] scan_table(input logic [15:0] src, input logic [15:0] dst);
      for (int i = 0; i < used; i++) begin
        if (ports[i] == dst) return lpwt_pkg::MATCH_DST;
        if (ports[i] == src) return lpwt_pkg::MATCH_SRC;
      end
      return lpwt_pkg::MATCH_NONE;
    endfunction

    function lpwt_pkg::result_t predict_outcome(input logic [1:0] kind,
                                                input watch_item_t it);
      lpwt_pkg::result_t r;
      logic [14:0]       learned;
      r = '0;
      case (kind)
        lpwt_pkg::KIND_ADD: begin
          if (it.port != 16'd0) begin
            if (append_port(it.port)) r.port_added = 1'b1;
            else r.table_full = 1'b1;
          end
        end
        lpwt_pkg::KIND_LOOKUP: r.match_code = scan_table(it.port, it.dst);
        lpwt_pkg::KIND_REPLY: begin
          if (it.port == lpwt_pkg::LISTENER_PORT && it.msg_type == lpwt_pkg::MSG_TYPE_REPLY &&
              it.b14 == lpwt_pkg::MSG_BYTE14_REQ && it.b15 == lpwt_pkg::MSG_BYTE15_REQ) begin
            learned = {it.b17[7:1] | {6'd0, it.b17[0]}, 1'b0, it.b16[6:0]};
            r.learned_port = learned;
            if (append_port({1'b0, learned})) r.port_added = 1'b1;
            else r.table_full = 1'b1;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_item(input logic [1:0] kind, input watch_item_t it);
      expected_results.push_back(predict_outcome(kind, it));
    endfunction

    function void report(input string field, input int unsigned want, input int unsigned got);
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(input logic [23:0] data);
      lpwt_pkg::result_t got;
      lpwt_pkg::result_t want;
      got = data[$bits(lpwt_pkg::result_t)-1:0];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        report("unexpected result, tdata", 0, data);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) mismatch_count++;
      if (got.match_code !== want.match_code)
        report("match_code", want.match_code, got.match_code);
      if (got.port_added !== want.port_added)
        report("port_added", want.port_added, got.port_added);
      if (got.table_full !== want.table_full)
        report("table_full", want.table_full, got.table_full);
      if (got.learned_port !== want.learned_port)
        report("learned_port", want.learned_port, got.learned_port);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  watch_table_scoreboard sb;
  int unsigned burst_left = 0;
  int unsigned quiet = 0;

  always #2 clk_i = ~clk_i;

  listener_port_watch_table_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rx_mode_e    mode;
    int unsigned phase_left;
    int unsigned tick;
    m_axis_tready = 1'b0;
    mode = RX_OPEN;
    phase_left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 300);
      end
      phase_left--;
      tick++;
      case (mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (tick % 10 == 0);
      endcase
    end
  end

  function automatic logic [15:0] known_port();
    return sb.ports[$urandom_range(0, sb.used - 1)];
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [15:0] port,
                           input logic [15:0] dst, input logic [7:0] msg_type,
                           input logic [7:0] b14, input logic [7:0] b15,
                           input logic [7:0] b16, input logic [7:0] b17);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {b17, b16, b15, b14, msg_type, dst, port};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned sel;
    logic [1:0]  kind;
    logic [15:0] port;
    logic [15:0] dst;
    logic [7:0]  msg_type;
    logic [7:0]  b14;
    logic [7:0]  b15;
    logic [7:0]  b16;
    logic [7:0]  b17;
    sb = new();
    sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = lpwt_pkg::KIND_ADD;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(lpwt_pkg::KIND_LOOKUP, 16'd3857, lpwt_pkg::LISTENER_PORT,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_LOOKUP, lpwt_pkg::LISTENER_PORT, 16'd4246,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_LOOKUP, 16'd3949, 16'd3949, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_LOOKUP, 16'd0, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(lpwt_pkg::KIND_ADD, 16'd0, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(lpwt_pkg::KIND_ADD, 16'hffff, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_ADD, 16'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_LOOKUP, 16'd0, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_REPLY, lpwt_pkg::LISTENER_PORT, 16'hffff,
              lpwt_pkg::MSG_TYPE_REPLY, lpwt_pkg::MSG_BYTE14_REQ,
              lpwt_pkg::MSG_BYTE15_REQ, 8'hff, 8'hff);
    send_item(lpwt_pkg::KIND_REPLY, lpwt_pkg::LISTENER_PORT, 16'd0,
              lpwt_pkg::MSG_TYPE_REPLY, lpwt_pkg::MSG_BYTE14_REQ,
              lpwt_pkg::MSG_BYTE15_REQ, 8'h80, 8'h00);
    send_item(lpwt_pkg::KIND_REPLY, lpwt_pkg::LISTENER_PORT, 16'd0,
              lpwt_pkg::MSG_TYPE_REPLY, lpwt_pkg::MSG_BYTE14_REQ,
              lpwt_pkg::MSG_BYTE15_REQ, 8'h7f, 8'h01);
    send_item(lpwt_pkg::KIND_REPLY, lpwt_pkg::LISTENER_PORT + 16'd1, 16'd0,
              lpwt_pkg::MSG_TYPE_REPLY, lpwt_pkg::MSG_BYTE14_REQ,
              lpwt_pkg::MSG_BYTE15_REQ, 8'h12, 8'h34);
    send_item(lpwt_pkg::KIND_REPLY, lpwt_pkg::LISTENER_PORT, 16'd0,
              lpwt_pkg::MSG_TYPE_REPLY + 8'd1, lpwt_pkg::MSG_BYTE14_REQ,
              lpwt_pkg::MSG_BYTE15_REQ, 8'h12, 8'h34);
    send_item(lpwt_pkg::KIND_REPLY, lpwt_pkg::LISTENER_PORT, 16'd0,
              lpwt_pkg::MSG_TYPE_REPLY, lpwt_pkg::MSG_BYTE14_REQ + 8'd1,
              lpwt_pkg::MSG_BYTE15_REQ, 8'h12, 8'h34);
    send_item(lpwt_pkg::KIND_REPLY, lpwt_pkg::LISTENER_PORT, 16'd0,
              lpwt_pkg::MSG_TYPE_REPLY, lpwt_pkg::MSG_BYTE14_REQ,
              lpwt_pkg::MSG_BYTE15_REQ - 8'd1, 8'h12, 8'h34);
    send_item(KIND_SPARE, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(lpwt_pkg::KIND_LOOKUP, 16'd0, 16'd12345, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_ADD, lpwt_pkg::LISTENER_PORT, 16'd0,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_LOOKUP, 16'd1, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(lpwt_pkg::KIND_LOOKUP, 16'hffff, 16'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    while (sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      port = $urandom_range(0, 65535);
      dst = $urandom_range(0, 65535);
      msg_type = $urandom_range(0, 255);
      b14 = $urandom_range(0, 255);
      b15 = $urandom_range(0, 255);
      b16 = $urandom_range(0, 255);
      b17 = $urandom_range(0, 255);
      if (pick < 3) begin
        kind = KIND_SPARE;
      end else if (pick < 25) begin
        kind = lpwt_pkg::KIND_ADD;
        sel = $urandom_range(0, 9);
        if (sel == 0) port = 16'd0;
        else if (sel < 3) port = known_port();
      end else if (pick < 70) begin
        kind = lpwt_pkg::KIND_LOOKUP;
        sel = $urandom_range(0, 4);
        case (sel)
          0: port = known_port();
          1: dst = known_port();
          2: begin
            port = known_port();
            dst = known_port();
          end
          3: begin
            port = known_port();
            dst = port;
          end
          default: ;
        endcase
      end else begin
        kind = lpwt_pkg::KIND_REPLY;
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
          port = lpwt_pkg::LISTENER_PORT;
          msg_type = lpwt_pkg::MSG_TYPE_REPLY;
          b14 = lpwt_pkg::MSG_BYTE14_REQ;
          b15 = lpwt_pkg::MSG_BYTE15_REQ;
          if (sel == 7) begin
            case ($urandom_range(0, 3))
              0: port = lpwt_pkg::LISTENER_PORT + 16'($urandom_range(1, 65535));
              1: msg_type = lpwt_pkg::MSG_TYPE_REPLY + 8'($urandom_range(1, 255));
              2: b14 = lpwt_pkg::MSG_BYTE14_REQ + 8'($urandom_range(1, 255));
              default: b15 = lpwt_pkg::MSG_BYTE15_REQ + 8'($urandom_range(1, 255));
            endcase
          end
        end
      end
      send_item(kind, port, dst, msg_type, b14, b15, b16, b17);
      sent++;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
